### design/dlis_pkg.sv
package dlis_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int NUM_QUEUES  = 3;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] NEWLINE_CHAR = 8'd10;
    localparam logic [7:0] DIGIT_ZERO   = 8'h30;
    localparam logic [7:0] DIGIT_NINE   = 8'h39;

    localparam logic CMD_CHAR  = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    localparam logic [2:0] ST_STORED     = 3'd0;
    localparam logic [2:0] ST_INVALID    = 3'd1;
    localparam logic [2:0] ST_OVERFLOW   = 3'd2;
    localparam logic [2:0] ST_QUEUE_FULL = 3'd3;
    localparam logic [2:0] ST_DRAINED    = 3'd4;
    localparam logic [2:0] ST_ALL_EMPTY  = 3'd5;

    localparam logic [1:0] Q_LOW  = 2'd0;
    localparam logic [1:0] Q_MID  = 2'd1;
    localparam logic [1:0] Q_HIGH = 2'd2;

    localparam logic REG_LOW_BORDER  = 1'b0;
    localparam logic REG_HIGH_BORDER = 1'b1;

    typedef logic [1:0]       qid_t;
    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef struct packed {
        logic        ok;
        logic        overflow;
        logic [31:0] value;
        logic [15:0] line_number;
    } line_info_t;

    typedef struct packed {
        logic [NUM_QUEUES-1:0] full;
        logic [NUM_QUEUES-1:0] nonempty;
        qid_t                  pop_q;
        logic [31:0]           pop_data;
        logic                  pop_last;
    } queue_status_t;

    function automatic ptr_t next_ptr(input ptr_t p);
        return (p == ptr_t'(QUEUE_DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
    endfunction

endpackage

### design/dlis_line_parser.sv
module dlis_line_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                advance,
    input  logic [7:0]          char_byte,
    output dlis_pkg::line_info_t info
);
    import dlis_pkg::*;

    logic [31:0] acc_reg, acc_next;
    logic        has_reg, has_next;
    logic        inv_reg, inv_next;
    logic        ovf_reg, ovf_next;
    logic [15:0] line_reg, line_next;
    logic [35:0] prod;
    logic [3:0]  digit;
    logic        is_digit;
    logic [15:0] line_sat;

    assign digit    = 4'(char_byte - DIGIT_ZERO);
    assign is_digit = (char_byte >= DIGIT_ZERO) && (char_byte <= DIGIT_NINE);
    assign prod     = {4'd0, acc_reg} * 36'd10 + {32'd0, digit};
    assign line_sat = (line_reg == 16'hFFFF) ? line_reg : 16'(line_reg + 1'b1);

    assign info.ok          = has_reg && !inv_reg;
    assign info.overflow    = ovf_reg;
    assign info.value       = acc_reg;
    assign info.line_number = line_sat;

    always_comb begin
        acc_next  = acc_reg;
        has_next  = has_reg;
        inv_next  = inv_reg;
        ovf_next  = ovf_reg;
        line_next = line_reg;
        if (advance) begin
            if (char_byte == NEWLINE_CHAR) begin
                acc_next  = '0;
                has_next  = 1'b0;
                inv_next  = 1'b0;
                ovf_next  = 1'b0;
                line_next = line_sat;
            end else begin
                has_next = 1'b1;
                if (!is_digit) begin
                    inv_next = 1'b1;
                end else if (!ovf_reg) begin
                    if (prod[35:32] != 4'd0) begin
                        ovf_next = 1'b1;
                    end else begin
                        acc_next = prod[31:0];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            has_reg  <= 1'b0;
            inv_reg  <= 1'b0;
            ovf_reg  <= 1'b0;
            line_reg <= '0;
        end else begin
            acc_reg  <= acc_next;
            has_reg  <= has_next;
            inv_reg  <= inv_next;
            ovf_reg  <= ovf_next;
            line_reg <= line_next;
        end
    end

endmodule

### design/dlis_queue_bank.sv
module dlis_queue_bank (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   push_en,
    input  dlis_pkg::qid_t         push_q,
    input  logic [31:0]            push_data,
    input  logic                   pop_en,
    output dlis_pkg::queue_status_t status
);
    import dlis_pkg::*;

    logic [31:0] mem_reg [NUM_QUEUES][QUEUE_DEPTH];
    logic [31:0] head_reg [NUM_QUEUES];
    ptr_t        rd_ptr_reg [NUM_QUEUES];
    ptr_t        wr_ptr_reg [NUM_QUEUES];
    cnt_t        cnt_reg [NUM_QUEUES];
    qid_t        pop_q;
    logic        others_zero;

    always_comb begin
        for (int q = 0; q < NUM_QUEUES; q++) begin
            status.full[q]     = (cnt_reg[q] == cnt_t'(QUEUE_DEPTH));
            status.nonempty[q] = (cnt_reg[q] != '0);
        end
    end

    // lowest nonempty queue wins
    always_comb begin
        if (status.nonempty[0]) begin
            pop_q = Q_LOW;
        end else if (status.nonempty[1]) begin
            pop_q = Q_MID;
        end else begin
            pop_q = Q_HIGH;
        end
    end

    always_comb begin
        others_zero = 1'b1;
        for (int q = 0; q < NUM_QUEUES; q++) begin
            if (qid_t'(q) != pop_q && cnt_reg[q] != '0) begin
                others_zero = 1'b0;
            end
        end
    end

    assign status.pop_q    = pop_q;
    assign status.pop_data = head_reg[pop_q];
    assign status.pop_last = others_zero && (cnt_reg[pop_q] == cnt_t'(1));

    // store the pushed value; hold each queue's oldest entry in head_reg,
    // loading it from the push into an empty queue or refilling it on a pop
    always_ff @(posedge aclk) begin
        if (push_en) begin
            mem_reg[push_q][wr_ptr_reg[push_q]] <= push_data;
        end
        if (push_en && cnt_reg[push_q] == '0) begin
            head_reg[push_q] <= push_data;
        end else if (pop_en) begin
            head_reg[pop_q] <= mem_reg[pop_q][next_ptr(rd_ptr_reg[pop_q])];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                rd_ptr_reg[q] <= '0;
                wr_ptr_reg[q] <= '0;
                cnt_reg[q]    <= '0;
            end
        end else begin
            for (int q = 0; q < NUM_QUEUES; q++) begin
                if (push_en && push_q == qid_t'(q)) begin
                    wr_ptr_reg[q] <= next_ptr(wr_ptr_reg[q]);
                end
                if (pop_en && pop_q == qid_t'(q)) begin
                    rd_ptr_reg[q] <= next_ptr(rd_ptr_reg[q]);
                end
                case ({push_en && push_q == qid_t'(q), pop_en && pop_q == qid_t'(q)})
                    2'b10:   cnt_reg[q] <= cnt_t'(cnt_reg[q] + 1'b1);
                    2'b01:   cnt_reg[q] <= cnt_t'(cnt_reg[q] - 1'b1);
                    default: cnt_reg[q] <= cnt_reg[q];
                endcase
            end
        end
    end

endmodule

### design/decimal_line_interval_sorter.sv
// Decimal line interval sorter.
// Input channel (s_valid/s_ready, s_cmd, s_char_byte): with s_cmd = 0 an item
// carries one text character; a newline (10) finishes the line, which is
// parsed as an unsigned 32-bit decimal value and pushed into the low, middle
// or high queue by comparing against low_border and high_border (APB
// registers at byte addresses 0 and 4). With s_cmd = 1 an item drains one
// value, low queue first, then middle, then high, oldest first.
// Result channel (m_valid/m_ready, m_status, m_number, m_queue_id,
// m_line_number, m_last): one item per finished line and per drain; plain
// characters yield none.
// Flow: an accepted item is captured in the input register and handled
// there; its result is then loaded into the output register, which drives
// m_valid. Throughput is one item per cycle unless a stalled result holds
// back a result-producing item; parse, classify and queue update act there.
// Reset (synchronous, aresetn low) empties all queues, clears the line state
// and line counter, and sets the borders to 0 and 4294967295.
// When the receiver stalls, the result is held; character items keep flowing
// behind it, and the first result-producing item waits in the input register.
module decimal_line_interval_sorter (
    input  logic        aclk,
    input  logic        aresetn,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input items
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_cmd,
    input  logic [7:0]  s_char_byte,
    // result items
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_number,
    output logic [1:0]  m_queue_id,
    output logic [15:0] m_line_number,
    output logic        m_last
);
    import dlis_pkg::*;

    logic [31:0]   low_border_reg;
    logic [31:0]   high_border_reg;
    logic          cfg_write;

    logic          in_valid_reg;
    logic          in_cmd_reg;
    logic [7:0]    in_char_reg;

    logic          out_valid_reg, out_valid_next;
    logic [2:0]    out_status_reg, out_status_next;
    logic [31:0]   out_number_reg, out_number_next;
    qid_t          out_qid_reg, out_qid_next;
    logic [15:0]   out_line_reg, out_line_next;
    logic          out_last_reg, out_last_next;

    logic          is_newline;
    logic          produces;
    logic          advance;
    logic          any_nonempty;
    qid_t          target_q;
    logic          push_en;
    logic          pop_en;
    line_info_t    info;
    queue_status_t qstat;

    // configuration port: writes decode on paddr[2] only
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_HIGH_BORDER) ? high_border_reg : low_border_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            low_border_reg  <= '0;
            high_border_reg <= '1;
        end else if (cfg_write) begin
            if (paddr[2] == REG_HIGH_BORDER) begin
                high_border_reg <= pwdata;
            end else begin
                low_border_reg <= pwdata;
            end
        end
    end

    // advance the held item unless its result has nowhere to go
    assign is_newline = (in_char_reg == NEWLINE_CHAR);
    assign produces   = (in_cmd_reg == CMD_DRAIN) || is_newline;
    assign advance    = in_valid_reg && (!produces || !out_valid_reg || m_ready);
    assign s_ready    = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_cmd_reg  <= s_cmd;
            in_char_reg <= s_char_byte;
        end
    end

    dlis_line_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance && (in_cmd_reg == CMD_CHAR)),
        .char_byte (in_char_reg),
        .info      (info)
    );

    // classify the finished value against the borders
    always_comb begin
        if (info.value < low_border_reg) begin
            target_q = Q_LOW;
        end else if (info.value <= high_border_reg) begin
            target_q = Q_MID;
        end else begin
            target_q = Q_HIGH;
        end
    end

    assign any_nonempty = |qstat.nonempty;
    assign pop_en  = advance && (in_cmd_reg == CMD_DRAIN) && any_nonempty;
    assign push_en = advance && (in_cmd_reg == CMD_CHAR) && is_newline && info.ok
                     && !info.overflow && !qstat.full[target_q];

    dlis_queue_bank u_queues (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_en   (push_en),
        .push_q    (target_q),
        .push_data (info.value),
        .pop_en    (pop_en),
        .status    (qstat)
    );

    // build the result of the item in the processing stage
    always_comb begin
        out_status_next = ST_STORED;
        out_number_next = '0;
        out_qid_next    = Q_LOW;
        out_line_next   = '0;
        out_last_next   = 1'b0;
        if (in_cmd_reg == CMD_DRAIN) begin
            if (any_nonempty) begin
                out_status_next = ST_DRAINED;
                out_number_next = qstat.pop_data;
                out_qid_next    = qstat.pop_q;
                out_last_next   = qstat.pop_last;
            end else begin
                out_status_next = ST_ALL_EMPTY;
            end
        end else begin
            out_line_next = info.line_number;
            if (!info.ok) begin
                out_status_next = ST_INVALID;
            end else if (info.overflow) begin
                out_status_next = ST_OVERFLOW;
            end else begin
                out_number_next = info.value;
                out_qid_next    = target_q;
                out_status_next = qstat.full[target_q] ? ST_QUEUE_FULL : ST_STORED;
            end
        end
    end

    // hold the result until taken; load a new one as it frees
    always_comb begin
        if (advance && produces) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && produces) begin
            out_status_reg <= out_status_next;
            out_number_reg <= out_number_next;
            out_qid_reg    <= out_qid_next;
            out_line_reg   <= out_line_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_status      = out_status_reg;
    assign m_number      = out_number_reg;
    assign m_queue_id    = out_qid_reg;
    assign m_line_number = out_line_reg;
    assign m_last        = out_last_reg;

    // a pop only ever hits a queue that holds something
    assert property (@(posedge aclk) disable iff (!aresetn)
        pop_en |-> qstat.nonempty[qstat.pop_q])
        else $error("pop from empty queue");

    // a push never overruns a full queue
    assert property (@(posedge aclk) disable iff (!aresetn)
        push_en |-> !qstat.full[target_q])
        else $error("push into full queue");

    // the result register never loads while a stalled result is pending
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_ready) |-> !(advance && produces))
        else $error("result overwritten while stalled");

    // reset leaves no result pending
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule
